// ===== sv/blpl_pkg.sv =====
// ----------------------------------------------------------------------------
// blpl_pkg: shared types and constants of the bounded positional list
// Command codes, status codes, sizes and the per-cell command record.
// ----------------------------------------------------------------------------
`default_nettype none

package blpl_pkg;

  localparam int CAPACITY    = 32;
  localparam int MAX_RESULTS = 32;
  localparam int MAX_CLIP    = (MAX_RESULTS < CAPACITY) ? MAX_RESULTS : CAPACITY;

  localparam int DATA_W = 32;
  localparam int POS_W  = 6;
  localparam int FUNC_W = 3;
  localparam int STAT_W = 3;
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int IDX_W  = $clog2(CAPACITY);
  localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;

  // command codes
  localparam logic [FUNC_W-1:0] FN_INS_FRONT = 3'd0;
  localparam logic [FUNC_W-1:0] FN_INS_BACK  = 3'd1;
  localparam logic [FUNC_W-1:0] FN_INS_AT    = 3'd2;
  localparam logic [FUNC_W-1:0] FN_DEL_FRONT = 3'd3;
  localparam logic [FUNC_W-1:0] FN_DEL_BACK  = 3'd4;
  localparam logic [FUNC_W-1:0] FN_DEL_AT    = 3'd5;
  localparam logic [FUNC_W-1:0] FN_FIND      = 3'd6;
  localparam logic [FUNC_W-1:0] FN_DUMP      = 3'd7;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY    = 3'd1;
  localparam logic [STAT_W-1:0] ST_RANGE    = 3'd2;
  localparam logic [STAT_W-1:0] ST_FULL     = 3'd3;
  localparam logic [STAT_W-1:0] ST_NOTFOUND = 3'd4;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INS,
    CELL_DEL,
    CELL_ROT
  } cell_op_t;

  // broadcast to every cell of the chain
  typedef struct packed {
    cell_op_t                  op;
    logic [CMP_W-1:0]          pos;       // insert / delete position
    logic [CMP_W-1:0]          last_idx;  // highest occupied cell, for rotate
    logic signed [DATA_W-1:0]  value;     // word to insert
  } cell_cmd_t;

endpackage

`default_nettype wire

// ===== sv/blpl_cell.sv =====
// ----------------------------------------------------------------------------
// blpl_cell: one storage cell of the list chain
// Holds one word; takes from its left or right neighbor, the head, or the
// broadcast value, and flags a match against the broadcast value.
// ----------------------------------------------------------------------------
`default_nettype none

module blpl_cell
  import blpl_pkg::*;
(
  input  wire logic                      clk,
  input  wire cell_cmd_t                 cmd,
  input  wire logic [IDX_W-1:0]          cell_idx,
  input  wire logic signed [DATA_W-1:0]  prev_data,
  input  wire logic signed [DATA_W-1:0]  next_data,
  input  wire logic signed [DATA_W-1:0]  head_data,
  output logic signed [DATA_W-1:0]       data,
  output logic                           match
);

  logic signed [DATA_W-1:0] data_r;
  logic signed [DATA_W-1:0] data_nxt;
  logic [CMP_W-1:0]         idx;

  assign idx   = CMP_W'(cell_idx);
  assign data  = data_r;
  assign match = (data_r == cmd.value);

  always_comb begin
    data_nxt = data_r;
    unique case (cmd.op)
      CELL_INS: begin
        if (idx > cmd.pos) data_nxt = prev_data;
        else if (idx == cmd.pos) data_nxt = cmd.value;
      end
      CELL_DEL: begin
        if (idx >= cmd.pos) data_nxt = next_data;
      end
      CELL_ROT: begin
        if (idx == cmd.last_idx) data_nxt = head_data;
        else if (idx < cmd.last_idx) data_nxt = next_data;
      end
      default: data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

endmodule

`default_nettype wire

// ===== sv/bounded_positional_list_unit.sv =====
// ----------------------------------------------------------------------------
// bounded_positional_list_unit: ordered list of signed words in a cell chain
// Insert, delete, find and dump commands over a row of shifting cells.
// ----------------------------------------------------------------------------
//
//  channel | dir | tdata (low bit up)                        | tuser    | tlast
//  --------+-----+-------------------------------------------+----------+------
//  in_     | in  | value[31:0], position[37:32], pad to 40   | func[2:0]| -
//  out_    | out | status[2:0], data_out[34:3],              | -        | last
//          |     | found_position[40:35], pad to 48          |          |
//
//  Insert and delete: every cell shifts toward or away from the position in
//  the same cycle and the result is registered.
//  Find: match flags are registered, then priority-encoded.
//  Dump reads one element per step: the chain rotates by one each cycle and
//  the head cell is read out, so after count steps the order is restored.
//  A stalled output pauses the rotation. New requests are taken only when
//  the unit is idle and the output register is free or being drained.
//  Reset (rst_n, synchronous) empties the list; cell contents are not reset.
// ----------------------------------------------------------------------------
`default_nettype none

module bounded_positional_list_unit
  import blpl_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  // request channel
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [39:0] in_tdata,   // value[31:0], position[37:32]
  input  wire logic [2:0]  in_tuser,   // func[2:0]
  // result channel
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [47:0]      out_tdata,  // status[2:0], data_out[34:3], found_position[40:35]
  output logic             out_tlast
);

  typedef enum logic [1:0] {S_IDLE, S_FIND, S_DUMP} state_t;

  state_t                   state_r;
  logic [CNT_W-1:0]         count_r;
  logic [CNT_W-1:0]         idx_r;
  logic [CAPACITY-1:0]      match_r;

  logic                     out_valid_r;
  logic [STAT_W-1:0]        out_status_r;
  logic signed [DATA_W-1:0] out_data_r;
  logic [POS_W-1:0]         out_pos_r;
  logic                     out_last_r;

  // request fields
  logic [FUNC_W-1:0]        in_func;
  logic signed [DATA_W-1:0] in_value;
  logic [POS_W-1:0]         in_position;
  logic                     in_acc;
  logic                     out_free;

  assign in_func     = in_tuser[FUNC_W-1:0];
  assign in_value    = in_tdata[DATA_W-1:0];
  assign in_position = in_tdata[DATA_W+POS_W-1:DATA_W];
  assign out_free    = !out_valid_r || out_tready;
  assign in_tready   = rst_n && (state_r == S_IDLE) && out_free;
  assign in_acc      = in_tvalid && in_tready;

  // chain
  cell_cmd_t                cmd;
  logic signed [DATA_W-1:0] cell_data [CAPACITY];
  logic [CAPACITY-1:0]      cell_match;

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    blpl_cell u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .cell_idx  (IDX_W'(g)),
      .prev_data ((g == 0) ? cell_data[0] : cell_data[(g == 0) ? 0 : g - 1]),
      .next_data ((g == CAPACITY - 1) ? cell_data[g]
                                      : cell_data[(g == CAPACITY - 1) ? g : g + 1]),
      .head_data (cell_data[0]),
      .data      (cell_data[g]),
      .match     (cell_match[g])
    );
  end

  // command decode: status and target position
  logic             is_ins, is_del;
  logic [CMP_W-1:0] tgt_pos;
  logic [CMP_W-1:0] cnt_ext;
  logic [STAT_W-1:0] mod_status;
  logic             mod_ok;

  assign cnt_ext = CMP_W'(count_r);

  always_comb begin
    is_ins  = 1'b0;
    is_del  = 1'b0;
    tgt_pos = '0;
    unique case (in_func)
      FN_INS_FRONT: begin is_ins = 1'b1; tgt_pos = '0; end
      FN_INS_BACK:  begin is_ins = 1'b1; tgt_pos = cnt_ext; end
      FN_INS_AT:    begin is_ins = 1'b1; tgt_pos = CMP_W'(in_position); end
      FN_DEL_FRONT: begin is_del = 1'b1; tgt_pos = '0; end
      FN_DEL_BACK:  begin is_del = 1'b1; tgt_pos = cnt_ext - CMP_W'(1); end
      FN_DEL_AT:    begin is_del = 1'b1; tgt_pos = CMP_W'(in_position); end
      default:      ;
    endcase
  end

  always_comb begin
    mod_status = ST_OK;
    if (is_ins) begin
      if (count_r == CNT_W'(CAPACITY)) mod_status = ST_FULL;
      else if (tgt_pos > cnt_ext) mod_status = ST_RANGE;
    end else begin
      if (count_r == '0) mod_status = ST_EMPTY;
      else if (tgt_pos >= cnt_ext) mod_status = ST_RANGE;
    end
  end

  assign mod_ok = (is_ins || is_del) && (mod_status == ST_OK);

  // dump control: the chain rotates count times, output stops past MAX_CLIP
  logic [CNT_W-1:0] dump_top;
  logic             dump_emit;
  logic             dump_step;

  assign dump_top  = (count_r > CNT_W'(MAX_CLIP)) ? CNT_W'(MAX_CLIP - 1)
                                                   : count_r - CNT_W'(1);
  assign dump_emit = (idx_r <= dump_top);
  assign dump_step = (state_r == S_DUMP) && (!dump_emit || out_free);

  // output register gets a new result this cycle
  logic out_load;

  assign out_load = (in_acc && (in_func != FN_FIND) &&
                     ((in_func != FN_DUMP) || (count_r == '0))) ||
                    (state_r == S_FIND) ||
                    (dump_step && dump_emit);

  always_comb begin
    cmd.op       = CELL_HOLD;
    cmd.pos      = tgt_pos;
    cmd.last_idx = cnt_ext - CMP_W'(1);
    cmd.value    = in_value;
    if (in_acc && mod_ok) cmd.op = is_ins ? CELL_INS : CELL_DEL;
    else if (dump_step) cmd.op = CELL_ROT;
  end

  // first match of the registered flags
  logic             any_match;
  logic [IDX_W-1:0] first_idx;

  assign any_match = |match_r;

  always_comb begin
    first_idx = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (match_r[i]) first_idx = IDX_W'(i);
    end
  end

  // valid-element mask for the find
  logic [CAPACITY-1:0] occ;
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      occ[i] = (CNT_W'(i) < count_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_load || (out_valid_r && !out_tready);
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            if (in_func == FN_FIND) begin
              match_r <= cell_match & occ;
              state_r <= S_FIND;
            end else if (in_func == FN_DUMP) begin
              idx_r <= '0;
              if (count_r == '0) begin
                out_status_r <= ST_EMPTY;
                out_data_r   <= '0;
                out_pos_r    <= '0;
                out_last_r   <= 1'b1;
              end else begin
                state_r <= S_DUMP;
              end
            end else begin
              out_status_r <= mod_status;
              out_data_r   <= '0;
              out_pos_r    <= '0;
              out_last_r   <= 1'b1;
              if (mod_ok) count_r <= is_ins ? count_r + CNT_W'(1) : count_r - CNT_W'(1);
            end
          end
        end
        S_FIND: begin
          // output register is always free here
          out_status_r <= any_match ? ST_OK : ST_NOTFOUND;
          out_data_r   <= '0;
          out_pos_r    <= any_match ? POS_W'(first_idx) : '0;
          out_last_r   <= 1'b1;
          state_r      <= S_IDLE;
        end
        S_DUMP: begin
          if (dump_step) begin
            if (dump_emit) begin
              out_status_r <= ST_OK;
              out_data_r   <= cell_data[0];
              out_pos_r    <= POS_W'(idx_r);
              out_last_r   <= (idx_r == dump_top);
            end
            idx_r <= idx_r + CNT_W'(1);
            if (idx_r == count_r - CNT_W'(1)) state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_pos_r, out_data_r, out_status_r};
  assign out_tlast  = out_last_r;

  // --------------------------------------------------------------------------
  // checks
  // --------------------------------------------------------------------------
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("element count above capacity");

  a_busy_no_req: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !in_tready)
    else $error("request taken while a command is in progress");

  a_ins_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && mod_ok && is_ins) |=> (count_r == $past(count_r) + CNT_W'(1)))
    else $error("successful insert did not grow the list");

  a_dump_count_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DUMP) |=> $stable(count_r))
    else $error("element count changed during dump");

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for bounded_positional_list_unit
// A queued driver sends list commands, and a behavioral list model predicts
// every result. A monitor compares each result with the oldest prediction.
// ----------------------------------------------------------------------------

module testbench;
  import blpl_pkg::*;

  localparam int STALL_LIMIT = 2000;  // cycles with no handshake on either side
  localparam int SETTLE_CYCLES = 40;  // quiet time after the last result

  typedef struct {
    logic [FUNC_W-1:0]        func;
    logic signed [DATA_W-1:0] value;
    logic [POS_W-1:0]         position;
  } list_cmd_t;

  typedef struct {
    logic [STAT_W-1:0]        status;
    logic signed [DATA_W-1:0] data;
    logic [POS_W-1:0]         found_pos;
    logic                     last;
  } list_reply_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata = '0;   // value[31:0], position[37:32]
  logic [2:0]  in_tuser = '0;   // func[2:0]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;       // status[2:0], data_out[34:3], found_position[40:35]
  logic        out_tlast;

  bounded_positional_list_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Shared bench state
  // --------------------------------------------------------------------------
  list_cmd_t   queued_cmds[$];      // commands not yet put on the bus
  list_reply_t awaited_replies[$];  // predicted results, oldest first
  list_cmd_t   live_cmd;            // request currently presented on in_*
  int          cmds_issued = 0;
  int          cmds_granted = 0;
  int          replies_checked = 0;
  int          fail_count = 0;
  int          quiet_cycles = 0;
  bit          calm = 1'b0;         // when set, neither side inserts gaps

  // Behavioral list: position i lives in held_words[i].
  logic signed [DATA_W-1:0] held_words[CAPACITY];
  int          held_count = 0;
  int          full_rejects = 0;
  int          longest_dump = 0;

  // Values that inserts and finds draw from, so finds hit and duplicates occur.
  logic signed [DATA_W-1:0] word_pool[8];

  // --------------------------------------------------------------------------
  // Prediction: apply one accepted command to the list, queue its results.
  // --------------------------------------------------------------------------
  function automatic void apply_list_command(list_cmd_t cmd);
    list_reply_t rep;
    int          slot;
    int          n;
    rep.status    = ST_OK;
    rep.data      = '0;
    rep.found_pos = '0;
    rep.last      = 1'b1;
    case (cmd.func)
      FN_INS_FRONT, FN_INS_BACK, FN_INS_AT: begin
        slot = (cmd.func == FN_INS_FRONT) ? 0 :
               (cmd.func == FN_INS_BACK)  ? held_count : int'(cmd.position);
        // fullness wins over a bad position
        if (held_count >= CAPACITY) begin
          rep.status = ST_FULL;
          full_rejects++;
        end else if (slot > held_count) begin
          rep.status = ST_RANGE;
        end else begin
          for (int i = held_count; i > slot; i--) held_words[i] = held_words[i-1];
          held_words[slot] = cmd.value;
          held_count++;
        end
      end
      FN_DEL_FRONT, FN_DEL_BACK, FN_DEL_AT: begin
        slot = (cmd.func == FN_DEL_FRONT) ? 0 :
               (cmd.func == FN_DEL_BACK)  ? held_count - 1 : int'(cmd.position);
        if (held_count == 0) begin
          rep.status = ST_EMPTY;
        end else if (slot >= held_count) begin
          rep.status = ST_RANGE;
        end else begin
          for (int i = slot; i + 1 < held_count; i++) held_words[i] = held_words[i+1];
          held_count--;
        end
      end
      FN_FIND: begin
        // first match wins; an empty list simply finds nothing
        rep.status = ST_NOTFOUND;
        for (int i = 0; i < held_count; i++) begin
          if (rep.status == ST_NOTFOUND && held_words[i] == cmd.value) begin
            rep.status    = ST_OK;
            rep.found_pos = POS_W'(i);
          end
        end
      end
      FN_DUMP: begin
        if (held_count == 0) begin
          rep.status = ST_EMPTY;
        end else begin
          n = (held_count < MAX_RESULTS) ? held_count : MAX_RESULTS;
          if (n > longest_dump) longest_dump = n;
          for (int i = 0; i < n; i++) begin
            rep.status    = ST_OK;
            rep.data      = held_words[i];
            rep.found_pos = POS_W'(i);
            rep.last      = (i == n - 1);
            awaited_replies.push_back(rep);
          end
          return;
        end
      end
    endcase
    awaited_replies.push_back(rep);
  endfunction

  function automatic void compare_field(string field, longint want, longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      fail_count++;
    end
  endfunction

  // --------------------------------------------------------------------------
  // Driver: hold a request until taken, then maybe pause, then load the next.
  // Prediction happens at the edge where the request is accepted.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : drive_requests
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
      in_tuser  <= '0;
    end else begin
      if (in_tvalid && in_tready) begin
        apply_list_command(live_cmd);
        cmds_granted++;
      end
      // slot is free when nothing is shown or the shown request just went
      if (!in_tvalid || in_tready) begin
        if (queued_cmds.size() != 0 && (calm || $urandom_range(0, 99) >= 12)) begin
          live_cmd = queued_cmds.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= {2'b00, live_cmd.position, live_cmd.value};
          in_tuser  <= live_cmd.func;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: check every accepted result, stall the result side at random.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : watch_results
    list_reply_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        replies_checked++;
        if (awaited_replies.size() == 0) begin
          $error("result with nothing awaited: tdata %h last %b", out_tdata, out_tlast);
          fail_count++;
        end else begin
          want = awaited_replies.pop_front();
          compare_field("status", want.status, out_tdata[2:0]);
          compare_field("data_out", want.data, $signed(out_tdata[34:3]));
          compare_field("found_position", want.found_pos, out_tdata[40:35]);
          compare_field("last", want.last, out_tlast);
        end
      end
      out_tready <= calm || ($urandom_range(0, 99) >= 12);
    end
  end

  // Watchdog: a long run of cycles with no handshake means a hang.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("timeout: no handshake for %0d cycles, %0d results outstanding",
                 STALL_LIMIT, awaited_replies.size());
        $display("simulation failed");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  task automatic queue_cmd(logic [FUNC_W-1:0] f, logic signed [DATA_W-1:0] v,
                           logic [POS_W-1:0] p);
    list_cmd_t c;
    c.func     = f;
    c.value    = v;
    c.position = p;
    queued_cmds.push_back(c);
    cmds_issued++;
  endtask

  // Sender holds off until every command is taken and every result is back.
  task automatic wait_until_settled();
    do @(posedge clk);
    while (cmds_granted != cmds_issued || awaited_replies.size() != 0);
  endtask

  // Mixed traffic, biased toward inserts so the list stays populated.
  task automatic queue_random_mix(int count);
    int                       pick;
    logic signed [DATA_W-1:0] word;
    logic [POS_W-1:0]         spot;
    for (int k = 0; k < count; k++) begin
      pick = $urandom_range(0, 99);
      word = ($urandom_range(0, 9) < 7) ? word_pool[$urandom_range(0, 7)] : $urandom;
      spot = ($urandom_range(0, 4) != 0) ? POS_W'($urandom_range(0, 8))
                                         : POS_W'($urandom_range(0, 63));
      if ($urandom_range(0, 9) == 0) word_pool[$urandom_range(0, 7)] = $urandom;
      if (pick < 15)      queue_cmd(FN_INS_FRONT, word, spot);
      else if (pick < 30) queue_cmd(FN_INS_BACK, word, spot);
      else if (pick < 45) queue_cmd(FN_INS_AT, word, spot);
      else if (pick < 53) queue_cmd(FN_DEL_FRONT, word, spot);
      else if (pick < 61) queue_cmd(FN_DEL_BACK, word, spot);
      else if (pick < 72) queue_cmd(FN_DEL_AT, word, spot);
      else if (pick < 87) queue_cmd(FN_FIND, word, spot);
      else if (pick < 94) queue_cmd(FN_DUMP, word, spot);
      else queue_cmd(FUNC_W'($urandom_range(0, 7)), $urandom, POS_W'($urandom_range(0, 63)));
    end
  endtask

  // Grow the list to capacity, poke it while full, then empty it again.
  // 40 inserts, more than capacity; an insert at position 1 into an empty list is refused.
  task automatic queue_fill_and_drain();
    int                       pick;
    logic signed [DATA_W-1:0] word;
    for (int k = 0; k < 40; k++) begin
      pick = $urandom_range(0, 2);
      word = ($urandom_range(0, 3) == 0) ? word_pool[$urandom_range(0, 7)] : $urandom;
      if (pick == 0)      queue_cmd(FN_INS_FRONT, word, POS_W'($urandom_range(0, 63)));
      else if (pick == 1) queue_cmd(FN_INS_BACK, word, POS_W'($urandom_range(0, 63)));
      else                queue_cmd(FN_INS_AT, word, POS_W'($urandom_range(0, 1)));
      if ($urandom_range(0, 5) == 0) queue_cmd(FN_FIND, word_pool[$urandom_range(0, 7)], '0);
    end
    // on a full list every insert kind is refused, even at a bad position
    queue_cmd(FN_DUMP, $urandom, '0);
    queue_cmd(FN_INS_AT, $urandom, 6'd63);
    queue_cmd(FN_INS_FRONT, $urandom, '0);
    queue_cmd(FN_INS_BACK, $urandom, '0);
    queue_cmd(FN_FIND, word_pool[$urandom_range(0, 7)], '0);
    queue_cmd(FN_DEL_AT, $urandom, 6'd31);
    queue_cmd(FN_DUMP, $urandom, '0);
    for (int k = 0; k < 40; k++) begin
      pick = $urandom_range(0, 2);
      if (pick == 0)      queue_cmd(FN_DEL_FRONT, $urandom, POS_W'($urandom_range(0, 63)));
      else if (pick == 1) queue_cmd(FN_DEL_BACK, $urandom, POS_W'($urandom_range(0, 63)));
      else                queue_cmd(FN_DEL_AT, $urandom, POS_W'($urandom_range(0, 2)));
    end
    queue_cmd(FN_DEL_BACK, $urandom, '0);
    queue_cmd(FN_DEL_BACK, $urandom, '0);
    queue_cmd(FN_DUMP, $urandom, '0);
  endtask

  initial begin
    word_pool[0] = 32'sh8000_0000;
    word_pool[1] = 32'sh7fff_ffff;
    word_pool[2] = '0;
    word_pool[3] = -32'sd1;
    for (int i = 4; i < 8; i++) word_pool[i] = $urandom;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty-list corners, extreme words, positions at and past the end
    queue_cmd(FN_DUMP, '0, '0);
    queue_cmd(FN_DEL_FRONT, '0, '0);
    queue_cmd(FN_DEL_BACK, '0, '0);
    queue_cmd(FN_DEL_AT, '0, 6'd63);
    queue_cmd(FN_FIND, '0, '0);
    queue_cmd(FN_INS_AT, 32'sd5, 6'd1);
    queue_cmd(FN_INS_FRONT, 32'sh8000_0000, '0);
    queue_cmd(FN_INS_BACK, 32'sh7fff_ffff, 6'd63);
    queue_cmd(FN_INS_AT, '0, 6'd1);
    queue_cmd(FN_INS_AT, -32'sd1, 6'd3);       // position equal to length appends
    queue_cmd(FN_INS_AT, 32'sd7, 6'd5);
    queue_cmd(FN_INS_AT, 32'sd7, 6'd63);
    queue_cmd(FN_FIND, -32'sd1, 6'd63);
    queue_cmd(FN_FIND, 32'sh7fff_ffff, '0);
    queue_cmd(FN_FIND, 32'sd12345, '0);
    queue_cmd(FN_DEL_AT, '0, 6'd4);
    queue_cmd(FN_DEL_AT, '0, 6'd63);
    queue_cmd(FN_DUMP, 32'sh7fff_ffff, 6'd63);
    queue_cmd(FN_DEL_AT, '0, 6'd1);
    queue_cmd(FN_DEL_FRONT, '0, '0);
    queue_cmd(FN_DEL_BACK, '0, '0);
    queue_cmd(FN_DUMP, '0, '0);
    queue_cmd(FN_DEL_AT, '0, '0);
    wait_until_settled();

    queue_random_mix(130);
    wait_until_settled();

    // back-to-back traffic with no gaps on either side
    calm = 1'b1;
    queue_fill_and_drain();
    queue_fill_and_drain();
    wait_until_settled();
    calm = 1'b0;

    queue_random_mix(120);
    wait_until_settled();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("%0d commands sent, %0d results compared", cmds_issued, replies_checked);
    $display("inserts refused on a full list: %0d, longest readout: %0d words",
             full_rejects, longest_dump);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/blpl_pkg.sv
sv/blpl_cell.sv
sv/bounded_positional_list_unit.sv
test/testbench.sv
